// ----- rtl/core/brg_pkg.sv -----
// shared constants, types and controller codes for the bounded random generator
package brg_pkg;

  // field and arithmetic widths
  localparam int WORD_W    = 31;
  localparam int MULT_W    = 15;
  localparam int PROD_W    = WORD_W + MULT_W;
  localparam int DIV_STEPS = WORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // minimal standard generator constants
  localparam logic [MULT_W-1:0] LCG_MULT = MULT_W'(16807);
  localparam logic [WORD_W-1:0] LCG_MOD  = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] SEED_ONE = WORD_W'(1);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD,
    ST_DIV,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;   // capture range limit of the accepted beat
    logic mul;    // register seed times multiplier
    logic fold;   // reduce product, update seed, start division
    logic step;   // one restoring division step
    logic emit;   // load the output register
  } cmd_t;

endpackage

// ----- rtl/core/brg_ctrl.sv -----
// controller state machine: sequencing, division step count and output valid
module brg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output brg_pkg::cmd_t cmd
);

  brg_pkg::state_t                state, state_next;
  logic [brg_pkg::CNT_W-1:0]      count, count_next;
  logic                           out_valid_next;

  // state, counter and valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brg_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      brg_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = brg_pkg::ST_MUL;
        end
      end
      brg_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = brg_pkg::ST_FOLD;
      end
      brg_pkg::ST_FOLD: begin
        cmd.fold   = 1'b1;
        count_next = '0;
        state_next = brg_pkg::ST_DIV;
      end
      brg_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (count == brg_pkg::CNT_W'(brg_pkg::DIV_STEPS - 1)) begin
          state_next = brg_pkg::ST_DONE;
        end else begin
          count_next = count + 1'b1;
        end
      end
      brg_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = brg_pkg::ST_IDLE;
        end
      end
      default: state_next = brg_pkg::ST_IDLE;
    endcase
  end

  // output valid: set on emit, cleared when the beat is taken
  always_comb begin
    priority if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign in_stall = (state != brg_pkg::ST_IDLE);

endmodule

// ----- rtl/core/brg_dp.sv -----
// datapath: seed register, multiply and fold, restoring divider, output register
module brg_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  brg_pkg::cmd_t              cmd,
  input  logic [brg_pkg::WORD_W-1:0] range_limit,
  output logic [brg_pkg::WORD_W-1:0] random_value
);

  logic [brg_pkg::WORD_W-1:0] seed;
  logic [brg_pkg::WORD_W-1:0] limit;
  logic [brg_pkg::PROD_W-1:0] prod;
  logic [brg_pkg::WORD_W-1:0] quo;
  logic [brg_pkg::WORD_W-1:0] rem;

  logic [brg_pkg::WORD_W-1:0] seed_eff;
  logic [brg_pkg::WORD_W:0]   fold_sum;
  logic [brg_pkg::WORD_W-1:0] seed_next;
  logic [brg_pkg::WORD_W:0]   trial;
  logic [brg_pkg::WORD_W:0]   trial_diff;
  logic                       trial_ge;

  // zero seed is forced to one
  assign seed_eff = (seed == '0) ? brg_pkg::SEED_ONE : seed;

  // mod 2^31-1: add high part to low part, subtract modulus once if needed
  assign fold_sum = {1'b0, prod[brg_pkg::WORD_W-1:0]}
                  + (brg_pkg::WORD_W + 1)'(prod[brg_pkg::PROD_W-1:brg_pkg::WORD_W]);
  always_comb begin
    if (fold_sum >= {1'b0, brg_pkg::LCG_MOD}) begin
      seed_next = brg_pkg::WORD_W'(fold_sum - {1'b0, brg_pkg::LCG_MOD});
    end else begin
      seed_next = fold_sum[brg_pkg::WORD_W-1:0];
    end
  end

  // one restoring division step
  assign trial      = {rem, quo[brg_pkg::WORD_W-1]};
  assign trial_diff = trial - {1'b0, limit};
  assign trial_ge   = (trial >= {1'b0, limit});

  // seed state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= brg_pkg::SEED_ONE;
    end else if (cmd.fold) begin
      seed <= seed_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      limit <= range_limit;
    end
    if (cmd.mul) begin
      prod <= brg_pkg::PROD_W'(seed_eff) * brg_pkg::PROD_W'(brg_pkg::LCG_MULT);
    end
    if (cmd.fold) begin
      quo <= seed_next;
      rem <= '0;
    end else if (cmd.step) begin
      quo <= {quo[brg_pkg::WORD_W-2:0], 1'b0};
      rem <= trial_ge ? trial_diff[brg_pkg::WORD_W-1:0] : trial[brg_pkg::WORD_W-1:0];
    end
    if (cmd.emit) begin
      random_value <= (limit == '0) ? '0 : rem;
    end
  end

endmodule

// ----- rtl/core/bounded_random_generator.sv -----
// top level: random value below a range limit from a minimal standard generator
// from input beat to output beat: multiply, fold, restoring divider at one quotient bit per cycle, emit
// one item at a time: a new beat waits for emit, and emit waits while a held result is stalled
// a finished result waits in the output register while the next beat is accepted
// reset: synchronous active high, seed returns to one, controller idle, no output valid
module bounded_random_generator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [brg_pkg::WORD_W-1:0] range_limit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [brg_pkg::WORD_W-1:0] random_value
);

  brg_pkg::cmd_t cmd;

  // sequencing
  brg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // arithmetic
  brg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .range_limit  (range_limit),
    .random_value (random_value)
  );

endmodule

// ----- rtl/core/brg_check.sv -----
// port-level checker for the bounded random generator and its bind
module brg_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [brg_pkg::WORD_W-1:0] random_value
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(random_value))
    else $error("output beat changed while stalled");

  // stays busy after an accepted beat, through the multiply and fold states
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input accepted again too soon");

  // a new result shows up as the block returns to idle
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while still busy");

  // reset leaves no output valid and the block idle
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("output valid or busy after reset");

endmodule

bind bounded_random_generator brg_check u_brg_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .random_value (random_value)
);

// ----- verif/tb_top.sv -----
// self-checking testbench for the bounded random generator with a queue-fed driver and monitor
`timescale 1ns / 100ps

module tb_top;

  localparam int          WORD_W         = brg_pkg::WORD_W;
  localparam int          CLK_HALF       = 4;
  localparam int          RESET_CYCLES   = 7;
  localparam int          RANDOM_ITEMS   = 600;
  localparam int          TAIL_ITEMS     = 60;
  localparam int          DRAIN_CYCLES   = 50;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [63:0] PM_MULTIPLIER  = 64'd16807;
  localparam logic [63:0] PM_MODULUS     = 64'd2147483647;

  typedef logic [WORD_W-1:0] word_t;

  logic  clk          = 1'b0;
  logic  rst          = 1'b1;
  logic  in_valid     = 1'b0;
  logic  in_stall;
  word_t range_limit  = '0;
  logic  out_valid;
  logic  out_stall    = 1'b0;
  word_t random_value;

  // limits waiting to be sent and values waiting to come back
  word_t pending_limits[$];
  word_t expected_values[$];

  word_t model_seed  = word_t'(1);
  logic  tail_phase  = 1'b0;
  int    gap_left    = 0;
  int    hold_left   = 0;
  int    idle_cycles = 0;
  int    errors      = 0;
  int    beats_in    = 0;
  int    checked     = 0;
  int    zero_limits = 0;

  bounded_random_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .range_limit  (range_limit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // advance the generator seed and reduce it by the range limit
  function automatic word_t predict_value(word_t limit);
    logic [63:0] seed;
    logic [63:0] product;
    seed = 64'(model_seed);
    if (seed == 64'd0) begin
      seed = 64'd1;
    end
    product    = seed * PM_MULTIPLIER;
    model_seed = word_t'(product % PM_MODULUS);
    if (limit == '0) begin
      return '0;
    end
    return word_t'(model_seed % limit);
  endfunction

  // random range limit, weighted toward small, power-of-two and near-maximum ranges
  function automatic word_t pick_limit();
    word_t base;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pick_limit = word_t'($urandom);
      4, 5:       pick_limit = word_t'($urandom_range(0, 32));
      6:          pick_limit = word_t'($urandom >> $urandom_range(1, 31));
      7: begin
        base       = word_t'(1) << $urandom_range(0, WORD_W - 1);
        pick_limit = base + word_t'($urandom_range(0, 2)) - word_t'(1);
      end
      8:          pick_limit = {WORD_W{1'b1}} - word_t'($urandom_range(0, 15));
      default:    pick_limit = word_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // driver: presents range limits, holds them while stalled, idles in bursts
  always @(posedge clk) begin : drive_limits
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (range_limit == '0) begin
          zero_limits++;
        end
        expected_values.push_back(predict_value(range_limit));
        beats_in++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_limits.size() > 0) begin
          if (!tail_phase && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 7) - 1;
            in_valid <= 1'b0;
          end else begin
            in_valid    <= 1'b1;
            range_limit <= pending_limits.pop_front();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      tail_phase <= (pending_limits.size() < TAIL_ITEMS);
    end
  end

  // monitor: checks each output beat against the oldest prediction, stalls in bursts
  always @(posedge clk) begin : check_values
    word_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          $error("random_value: expected none, actual %0d", random_value);
          errors++;
        end else begin
          want = expected_values.pop_front();
          if (random_value !== want) begin
            $error("random_value: expected %0d, actual %0d", want, random_value);
            errors++;
          end
          checked++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 7) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    // directed: extremes, zero range, edges around single-bit values, generator constants
    pending_limits.push_back(word_t'(1));
    pending_limits.push_back(word_t'(0));
    pending_limits.push_back(word_t'(2));
    pending_limits.push_back(word_t'(3));
    pending_limits.push_back({WORD_W{1'b1}});
    pending_limits.push_back({WORD_W{1'b1}} - word_t'(1));
    pending_limits.push_back(word_t'(0));
    pending_limits.push_back(word_t'(1) << (WORD_W - 1));
    pending_limits.push_back((word_t'(1) << (WORD_W - 1)) - word_t'(1));
    pending_limits.push_back((word_t'(1) << (WORD_W - 1)) + word_t'(1));
    pending_limits.push_back(word_t'(31'h5555_5555));
    pending_limits.push_back(word_t'(31'h2AAA_AAAA));
    pending_limits.push_back(word_t'(16807));
    pending_limits.push_back(word_t'(127773));
    pending_limits.push_back(word_t'(2836));
    pending_limits.push_back(word_t'(65536));
    pending_limits.push_back(word_t'(7));
    pending_limits.push_back(word_t'(10));
    pending_limits.push_back(word_t'(1000));
    pending_limits.push_back(word_t'(1));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pending_limits.push_back(pick_limit());
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending_limits.size() > 0 || in_valid || expected_values.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_values.size() != 0) begin
      $error("random_value: %0d expected values never arrived", expected_values.size());
      errors++;
    end

    $display("sent %0d range limits (%0d of them zero), checked %0d random values",
             beats_in, zero_limits, checked);
    $display("stimulus mixed full-width, small, power-of-two and near-maximum ranges");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/brg_pkg.sv
rtl/core/brg_ctrl.sv
rtl/core/brg_dp.sv
rtl/core/bounded_random_generator.sv
rtl/core/brg_check.sv
verif/tb_top.sv
